[hw/rtl/m3ema_pkg.sv]
// ----------------------------------------------------------------------------
// m3ema_pkg
// shared types and constants of the median-of-three / moving-average
// altitude filter
// ----------------------------------------------------------------------------
package m3ema_pkg;

    localparam int unsigned ALPHA_WIDTH = 16;
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = 16'd13107;
    localparam int unsigned RING_DEPTH = 3;
    localparam int unsigned SLOT_WIDTH = 2;

    localparam logic [SLOT_WIDTH-1:0] SLOT_FIRST = 2'd0;
    localparam logic [SLOT_WIDTH-1:0] SLOT_SECOND = 2'd1;
    localparam logic [SLOT_WIDTH-1:0] SLOT_LAST = 2'd2;

    localparam logic [SLOT_WIDTH-1:0] FILL_EMPTY = 2'd0;
    localparam logic [SLOT_WIDTH-1:0] FILL_ONE = 2'd1;
    localparam logic [SLOT_WIDTH-1:0] FILL_TWO = 2'd2;
    localparam logic [SLOT_WIDTH-1:0] FILL_FULL = 2'd3;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    typedef struct packed {
        logic fire;
        logic clear;
    } t_step_ctrl;

endpackage

[hw/rtl/m3ema_window.sv]
// ----------------------------------------------------------------------------
// m3ema_window
// three-entry sample ring, fill tracking; median of three, max while filling
// ----------------------------------------------------------------------------
module m3ema_window #(
    parameter int unsigned ALT_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  m3ema_pkg::t_step_ctrl         i_ctrl,
    input  logic signed [ALT_WIDTH-1:0]   i_sample,
    output logic signed [ALT_WIDTH-1:0]   o_median
);

    logic signed [ALT_WIDTH-1:0] r_ring [m3ema_pkg::RING_DEPTH];
    logic [m3ema_pkg::SLOT_WIDTH-1:0] r_write_slot;
    logic [m3ema_pkg::SLOT_WIDTH-1:0] r_fill_count;
    logic [m3ema_pkg::SLOT_WIDTH-1:0] n_write_slot;
    logic [m3ema_pkg::SLOT_WIDTH-1:0] n_fill_count;

    logic signed [ALT_WIDTH-1:0] v0, v1, v2;
    logic signed [ALT_WIDTH-1:0] lo01, hi01, lo_hi2;

    // ring contents including the sample written this item
    always_comb begin
        v0 = (r_write_slot == m3ema_pkg::SLOT_FIRST) ? i_sample : r_ring[0];
        v1 = (r_write_slot == m3ema_pkg::SLOT_SECOND) ? i_sample : r_ring[1];
        v2 = (r_write_slot == m3ema_pkg::SLOT_LAST) ? i_sample : r_ring[2];
    end

    always_comb begin
        n_write_slot = (r_write_slot == m3ema_pkg::SLOT_LAST) ? m3ema_pkg::SLOT_FIRST
                                                               : r_write_slot + 2'd1;
        n_fill_count = (r_fill_count == m3ema_pkg::FILL_FULL) ? m3ema_pkg::FILL_FULL
                                                               : r_fill_count + 2'd1;
    end

    always_comb begin
        lo01   = (v0 < v1) ? v0 : v1;
        hi01   = (v0 > v1) ? v0 : v1;
        lo_hi2 = (hi01 < v2) ? hi01 : v2;
        case (n_fill_count)
            m3ema_pkg::FILL_EMPTY,
            m3ema_pkg::FILL_ONE: o_median = v0;
            m3ema_pkg::FILL_TWO: o_median = hi01;
            default:             o_median = (lo01 > lo_hi2) ? lo01 : lo_hi2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot <= m3ema_pkg::SLOT_FIRST;
            r_fill_count <= m3ema_pkg::FILL_EMPTY;
        end else if (i_ctrl.fire) begin
            if (i_ctrl.clear) begin
                r_write_slot <= m3ema_pkg::SLOT_FIRST;
                r_fill_count <= m3ema_pkg::FILL_EMPTY;
            end else begin
                r_write_slot <= n_write_slot;
                r_fill_count <= n_fill_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire && !i_ctrl.clear) begin
            r_ring[r_write_slot] <= i_sample;
        end
    end

endmodule

[hw/rtl/m3ema_smoother.sv]
// ----------------------------------------------------------------------------
// m3ema_smoother
// gain register, seed flag and floored multiply-add moving average with
// saturation to the altitude range
// ----------------------------------------------------------------------------
module m3ema_smoother #(
    parameter int unsigned ALT_WIDTH       = 24,
    parameter int unsigned ALPHA_FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [m3ema_pkg::ALPHA_WIDTH-1:0]      i_cfg_wr_data,
    input  m3ema_pkg::t_step_ctrl                  i_ctrl,
    input  logic signed [ALT_WIDTH-1:0]            i_median,
    output logic signed [ALT_WIDTH-1:0]            o_filtered
);

    localparam int unsigned DIFF_W = ALT_WIDTH + 1;
    localparam int unsigned PROD_W = DIFF_W + m3ema_pkg::ALPHA_WIDTH + 1;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-ALT_WIDTH+1){1'b0}}, {(ALT_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

    logic [m3ema_pkg::ALPHA_WIDTH-1:0] r_alpha;
    logic signed [ALT_WIDTH-1:0] r_smoothed;
    logic signed [ALT_WIDTH-1:0] n_smoothed;
    logic r_seeded;

    logic signed [DIFF_W-1:0] diff;
    logic signed [m3ema_pkg::ALPHA_WIDTH:0] alpha_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] step;
    logic signed [SUM_W-1:0] smooth_ext;
    logic signed [SUM_W-1:0] step_ext;
    logic signed [SUM_W-1:0] sum;

    always_comb begin
        diff       = {i_median[ALT_WIDTH-1], i_median} - {r_smoothed[ALT_WIDTH-1], r_smoothed};
        alpha_s    = {1'b0, r_alpha};
        prod       = diff * alpha_s;
        step       = prod >>> ALPHA_FRAC_BITS;
        smooth_ext = {{(SUM_W-ALT_WIDTH){r_smoothed[ALT_WIDTH-1]}}, r_smoothed};
        step_ext   = {step[PROD_W-1], step};
        sum        = smooth_ext + step_ext;
        if (i_ctrl.clear) begin
            n_smoothed = '0;
        end else if (!r_seeded) begin
            n_smoothed = i_median;
        end else if (sum > SAT_MAX) begin
            n_smoothed = SAT_MAX[ALT_WIDTH-1:0];
        end else if (sum < SAT_MIN) begin
            n_smoothed = SAT_MIN[ALT_WIDTH-1:0];
        end else begin
            n_smoothed = sum[ALT_WIDTH-1:0];
        end
    end

    assign o_filtered = n_smoothed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= m3ema_pkg::ALPHA_RESET;
        end else if (i_cfg_wr_en) begin
            r_alpha <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothed <= '0;
            r_seeded   <= 1'b0;
        end else if (i_ctrl.fire) begin
            r_smoothed <= n_smoothed;
            r_seeded   <= !i_ctrl.clear;
        end
    end

endmodule

[hw/rtl/median3_ema_altitude_filter_core.sv]
// ----------------------------------------------------------------------------
// median3_ema_altitude_filter_core
// median-of-three spike rejection followed by an exponential moving average
// on barometric altitude samples
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        tdata: raw_altitude, tuser: op
//  m_axis    out        tvalid / tready        tdata: filtered, median
//  cfg       in         i_cfg_wr_en            i_cfg_wr_data: smoothing_alpha
//
// one item per cycle sustained while m_axis_tready stays high. an item in the
// input register is processed once the result register is free or drained;
// the compare network and gain multiply-add sit between the two registers.
// a stalled result holds one item while one more waits in the input
// register. synchronous active-low reset.
// ----------------------------------------------------------------------------
module median3_ema_altitude_filter_core #(
    parameter int unsigned ALT_WIDTH       = 24,
    parameter int unsigned ALPHA_FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [m3ema_pkg::ALPHA_WIDTH-1:0]      i_cfg_wr_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // raw_altitude, zero pad
    input  logic [((ALT_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    // op
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // filtered_altitude, median_altitude, zero pad
    output logic [((2*ALT_WIDTH+7)/8)*8-1:0]       m_axis_tdata
);

    localparam int unsigned OUT_W = ((2*ALT_WIDTH+7)/8)*8;

    logic r_in_valid;
    m3ema_pkg::t_op r_in_op;
    logic signed [ALT_WIDTH-1:0] r_in_raw;

    logic r_out_valid;
    logic signed [ALT_WIDTH-1:0] r_out_filtered;
    logic signed [ALT_WIDTH-1:0] r_out_median;

    m3ema_pkg::t_step_ctrl ctrl;
    logic signed [ALT_WIDTH-1:0] median;
    logic signed [ALT_WIDTH-1:0] filtered;

    always_comb begin
        ctrl.fire  = r_in_valid && (!r_out_valid || m_axis_tready);
        ctrl.clear = (r_in_op == m3ema_pkg::OP_CLEAR);
    end

    assign s_axis_tready = !r_in_valid || ctrl.fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (ctrl.fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op  <= m3ema_pkg::t_op'(s_axis_tuser);
            r_in_raw <= s_axis_tdata[ALT_WIDTH-1:0];
        end
    end

    m3ema_window #(
        .ALT_WIDTH (ALT_WIDTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_sample (r_in_raw),
        .o_median (median)
    );

    m3ema_smoother #(
        .ALT_WIDTH       (ALT_WIDTH),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_smoother (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ctrl        (ctrl),
        .i_median      (median),
        .o_filtered    (filtered)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.fire) begin
            r_out_filtered <= filtered;
            r_out_median   <= ctrl.clear ? '0 : median;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_median, r_out_filtered});

    // a clear item yields an all-zero result
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.fire && ctrl.clear |=> m_axis_tvalid && (m_axis_tdata == '0))
        else $error("clear item gave nonzero result");

    // each processed item lands in the result register
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.fire |=> m_axis_tvalid)
        else $error("processed item lost");

    // input side only stalls when both stages hold an item
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled with room available");

endmodule
